FILE: rtl/bilateral_filter_3x3_top_defines.svh
// assertion macros shared by the checker
`ifndef BILATERAL_FILTER_3X3_TOP_DEFINES_SVH
`define BILATERAL_FILTER_3X3_TOP_DEFINES_SVH

// same-cycle implication
`define BF3_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bf3 assertion failed");

// next-cycle implication
`define BF3_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bf3 assertion failed");

`endif

FILE: rtl/bf3_pkg.sv
`default_nettype none
package bf3_pkg;

    localparam int WIDTH_MAX        = 1024;
    localparam int HEIGHT_MAX       = 1024;
    localparam int WEIGHT_FRAC_BITS = 16;

    localparam int PIX_W      = 8;
    localparam int DIM_W      = 11;
    localparam int COL_W      = $clog2(WIDTH_MAX);
    localparam int ROW_W      = $clog2(HEIGHT_MAX) + 1;
    localparam int LINE_W     = 2 * PIX_W;
    localparam int WGT_W      = WEIGHT_FRAC_BITS + 1;
    localparam int TAP_W      = 2 * WEIGHT_FRAC_BITS + 1;
    localparam int DEN_W      = TAP_W + 4;
    localparam int NUM_W      = DEN_W + PIX_W;
    localparam int TBL_DEPTH  = 256;
    localparam int TBL_AW     = 8;
    localparam int FIELD_WGT_W = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_CTR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_EDGE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPATIAL_CRN   = 3'd4;

    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_TABLE = 2'd1;
    localparam logic [1:0] KIND_DRAIN = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [8:0] window_t;
    typedef logic [WGT_W-1:0] wgt_t;

    typedef struct packed {
        logic [1:0] lc;
        logic [1:0] cc;
        logic [1:0] rc;
    } col_sel_t;

    typedef struct packed {
        logic              we;
        logic [TBL_AW-1:0] addr;
        wgt_t              data;
    } tbl_wr_t;

    typedef struct packed {
        pix_t value;
        logic zero_weight;
    } filt_res_t;

    function automatic wgt_t sat_weight(input logic [FIELD_WGT_W-1:0] v);
        logic [31:0] one;
        one = 32'd1 << WEIGHT_FRAC_BITS;
        if (32'(v) > one)
            return wgt_t'(one);
        else
            return wgt_t'(v);
    endfunction

endpackage
`default_nettype wire

FILE: rtl/bf3_ram.sv
`default_nettype none
module bf3_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/bf3_filter_core.sv
`default_nettype none
module bf3_filter_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire bf3_pkg::col_sel_t  sel,
    input  wire bf3_pkg::window_t   win,
    input  wire bf3_pkg::wgt_t      sp_center,
    input  wire bf3_pkg::wgt_t      sp_edge,
    input  wire bf3_pkg::wgt_t      sp_corner,
    input  wire bf3_pkg::tbl_wr_t   tbl_wr,
    output logic                    done,
    output bf3_pkg::filt_res_t      res
);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_TAP  = 3'b010,
        C_DIV  = 3'b100
    } core_state_t;

    core_state_t state_reg;
    logic [3:0] tap_cnt_reg;
    logic [1:0] tr_reg;
    logic [1:0] tk_reg;
    logic s1_valid_reg;
    bf3_pkg::pix_t s1_p_reg;
    bf3_pkg::wgt_t s1_sp_reg;
    logic s2_valid_reg;
    logic [bf3_pkg::TAP_W-1:0] s2_w_reg;
    bf3_pkg::pix_t s2_p_reg;
    logic [bf3_pkg::NUM_W-1:0] num_reg;
    logic [bf3_pkg::DEN_W-1:0] den_reg;
    logic [bf3_pkg::NUM_W-1:0] dsh_reg;
    bf3_pkg::pix_t q_reg;
    logic [2:0] bit_reg;
    logic done_reg;
    bf3_pkg::filt_res_t res_reg;

    logic [1:0] col;
    bf3_pkg::pix_t p_issue;
    bf3_pkg::pix_t centre;
    bf3_pkg::pix_t diff;
    bf3_pkg::wgt_t sp_sel;
    bf3_pkg::wgt_t tbl_rdata;
    logic [2*bf3_pkg::WGT_W-1:0] prod;
    logic [bf3_pkg::NUM_W-1:0] num_acc;
    logic [bf3_pkg::DEN_W-1:0] den_acc;
    logic ge;

    bf3_ram #(.DEPTH(bf3_pkg::TBL_DEPTH), .WIDTH(bf3_pkg::WGT_W)) u_tbl (
        .clk   (clk),
        .we    (tbl_wr.we),
        .waddr (tbl_wr.addr),
        .wdata (tbl_wr.data),
        .raddr (diff),
        .rdata (tbl_rdata)
    );

    always_comb
    begin
        case (tk_reg)
            2'd0:    col = sel.lc;
            2'd1:    col = sel.cc;
            default: col = sel.rc;
        endcase
        p_issue = win[4'(tr_reg) * 4'd3 + 4'(col)];
        centre  = win[4'd3 + 4'(sel.cc)];
        diff    = (p_issue > centre) ? p_issue - centre : centre - p_issue;
        if (tr_reg == 2'd1 && tk_reg == 2'd1)
            sp_sel = sp_center;
        else if (tr_reg == 2'd1 || tk_reg == 2'd1)
            sp_sel = sp_edge;
        else
            sp_sel = sp_corner;
        prod = s1_sp_reg * tbl_rdata;
        num_acc = num_reg;
        den_acc = den_reg;
        if (s2_valid_reg)
        begin
            num_acc = num_reg + bf3_pkg::NUM_W'(s2_w_reg) * bf3_pkg::NUM_W'(s2_p_reg);
            den_acc = den_reg + bf3_pkg::DEN_W'(s2_w_reg);
        end
        ge = num_reg >= dsh_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= C_IDLE;
            tap_cnt_reg  <= '0;
            tr_reg       <= '0;
            tk_reg       <= '0;
            s1_valid_reg <= 1'b0;
            s1_p_reg     <= '0;
            s1_sp_reg    <= '0;
            s2_valid_reg <= 1'b0;
            s2_w_reg     <= '0;
            s2_p_reg     <= '0;
            num_reg      <= '0;
            den_reg      <= '0;
            dsh_reg      <= '0;
            q_reg        <= '0;
            bit_reg      <= '0;
            done_reg     <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            done_reg <= state_reg == C_DIV && bit_reg == 3'd0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        tap_cnt_reg  <= '0;
                        tr_reg       <= '0;
                        tk_reg       <= '0;
                        s1_valid_reg <= 1'b0;
                        s2_valid_reg <= 1'b0;
                        num_reg      <= '0;
                        den_reg      <= '0;
                        state_reg    <= C_TAP;
                    end
                end
                C_TAP:
                begin
                    // three-step pipe: table read, weight product, accumulate
                    if (tap_cnt_reg < 4'd9)
                    begin
                        s1_valid_reg <= 1'b1;
                        s1_p_reg     <= p_issue;
                        s1_sp_reg    <= sp_sel;
                        if (tk_reg == 2'd2)
                        begin
                            tk_reg <= '0;
                            tr_reg <= tr_reg + 2'd1;
                        end
                        else
                        begin
                            tk_reg <= tk_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        s1_valid_reg <= 1'b0;
                    end
                    s2_valid_reg <= s1_valid_reg;
                    s2_w_reg     <= bf3_pkg::TAP_W'(prod);
                    s2_p_reg     <= s1_p_reg;
                    num_reg      <= num_acc;
                    den_reg      <= den_acc;
                    tap_cnt_reg  <= tap_cnt_reg + 4'd1;
                    if (tap_cnt_reg == 4'd10)
                    begin
                        dsh_reg   <= bf3_pkg::NUM_W'(den_acc) << (bf3_pkg::PIX_W - 1);
                        q_reg     <= '0;
                        bit_reg   <= 3'(bf3_pkg::PIX_W - 1);
                        state_reg <= C_DIV;
                    end
                end
                C_DIV:
                begin
                    // restoring division, one quotient bit per cycle
                    if (ge)
                    begin
                        num_reg <= num_reg - dsh_reg;
                    end
                    q_reg   <= {q_reg[bf3_pkg::PIX_W-2:0], ge};
                    dsh_reg <= dsh_reg >> 1;
                    if (bit_reg == 3'd0)
                    begin
                        if (den_reg == '0)
                        begin
                            res_reg.value       <= centre;
                            res_reg.zero_weight <= 1'b1;
                        end
                        else
                        begin
                            res_reg.value       <= {q_reg[bf3_pkg::PIX_W-2:0], ge};
                            res_reg.zero_weight <= 1'b0;
                        end
                        state_reg <= C_IDLE;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 3'd1;
                    end
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
`default_nettype wire

FILE: rtl/bilateral_filter_3x3_top.sv
// a pixel or drain item first passes the line-store access, then each of its results
// runs 9 serial taps through one table port and an 8-step divider
// an item yields no, one or two results; no new item is taken until they are pushed,
// but table loads and ignored items leave in_ready high
// reset: async active low; then a clearing pass zeroes the line store
// with in_ready low; config writes are taken throughout
`default_nettype none
module bilateral_filter_3x3_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [1:0]                       kind,
    input  wire logic [bf3_pkg::PIX_W-1:0]        pixel_value,
    input  wire logic [bf3_pkg::TBL_AW-1:0]       table_index,
    input  wire logic [bf3_pkg::FIELD_WGT_W-1:0]  table_weight,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [bf3_pkg::PIX_W-1:0]             filtered_pixel,
    output logic                                  row_end,
    output logic                                  frame_end,
    output logic                                  zero_weight,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [bf3_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bf3_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_RUN   = 5'b01000,
        S_PUSH  = 5'b10000
    } top_state_t;

    top_state_t state_reg;
    logic [bf3_pkg::COL_W-1:0] clr_cnt_reg;
    logic [bf3_pkg::DIM_W-1:0] width_reg;
    logic [bf3_pkg::DIM_W-1:0] height_reg;
    logic [bf3_pkg::CFG_DATA_W-1:0] sp_ctr_reg;
    logic [bf3_pkg::CFG_DATA_W-1:0] sp_edge_reg;
    logic [bf3_pkg::CFG_DATA_W-1:0] sp_crn_reg;
    logic [bf3_pkg::ROW_W-1:0] row_count_reg;
    logic [bf3_pkg::COL_W-1:0] col_count_reg;
    bf3_pkg::window_t win_reg;
    logic drain_reg;
    bf3_pkg::pix_t p_reg;
    bf3_pkg::col_sel_t sel_reg;
    logic pend2_reg;
    logic cur_row_end_reg;
    logic cur_frame_end_reg;
    logic frame_end2_reg;
    bf3_pkg::filt_res_t hold_reg;
    logic out_valid_reg;
    bf3_pkg::pix_t out_pix_reg;
    logic out_row_end_reg;
    logic out_frame_end_reg;
    logic out_zero_reg;

    logic [bf3_pkg::DIM_W-1:0] w_cl;
    logic [bf3_pkg::DIM_W-1:0] h_cl;
    logic accept;
    logic draining;
    logic last;
    logic emit_any;
    logic can_load;
    logic core_start;
    logic core_done;
    bf3_pkg::filt_res_t core_res;
    bf3_pkg::tbl_wr_t tbl_wr;
    logic line_we;
    logic [bf3_pkg::COL_W-1:0] line_waddr;
    logic [bf3_pkg::LINE_W-1:0] line_wdata;
    logic [bf3_pkg::LINE_W-1:0] line_rdata;
    bf3_pkg::pix_t la;
    bf3_pkg::pix_t lb;
    bf3_pkg::pix_t sh_top;
    bf3_pkg::pix_t sh_mid;
    bf3_pkg::pix_t sh_bot;

    function automatic logic [bf3_pkg::DIM_W-1:0] clamp_dim(
        input logic [bf3_pkg::DIM_W-1:0] v, input int maxv);
        if (v < bf3_pkg::DIM_W'(2))
            return bf3_pkg::DIM_W'(2);
        else if (32'(v) > 32'(maxv))
            return bf3_pkg::DIM_W'(maxv);
        else
            return v;
    endfunction

    assign w_cl      = clamp_dim(width_reg, bf3_pkg::WIDTH_MAX);
    assign h_cl      = clamp_dim(height_reg, bf3_pkg::HEIGHT_MAX);
    assign in_ready  = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && in_ready;
    assign draining  = 32'(row_count_reg) >= 32'(h_cl);
    assign last      = 32'(col_count_reg) >= 32'(w_cl) - 32'd1;
    assign emit_any  = col_count_reg != '0 && (drain_reg || row_count_reg != '0);
    assign can_load  = !out_valid_reg || out_ready;
    assign core_start = (state_reg == S_READ && emit_any)
                     || (state_reg == S_PUSH && can_load && pend2_reg);

    assign la = line_rdata[bf3_pkg::LINE_W-1:bf3_pkg::PIX_W];
    assign lb = line_rdata[bf3_pkg::PIX_W-1:0];

    always_comb
    begin
        tbl_wr.we   = accept && kind == bf3_pkg::KIND_TABLE;
        tbl_wr.addr = table_index;
        tbl_wr.data = bf3_pkg::sat_weight(table_weight);

        // mirrored rows: row -1 reads as row 1, row H as row H-2
        if (drain_reg)
        begin
            sh_top = la;
            sh_mid = lb;
            sh_bot = la;
        end
        else
        begin
            sh_top = (row_count_reg == bf3_pkg::ROW_W'(1)) ? p_reg : la;
            sh_mid = lb;
            sh_bot = p_reg;
        end

        if (state_reg == S_CLEAR)
        begin
            line_we    = 1'b1;
            line_waddr = clr_cnt_reg;
            line_wdata = '0;
        end
        else
        begin
            line_we    = state_reg == S_READ && !drain_reg;
            line_waddr = col_count_reg;
            line_wdata = {lb, p_reg};
        end
    end

    bf3_ram #(.DEPTH(bf3_pkg::WIDTH_MAX), .WIDTH(bf3_pkg::LINE_W)) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (line_wdata),
        .raddr (col_count_reg),
        .rdata (line_rdata)
    );

    bf3_filter_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (core_start),
        .sel       (sel_reg),
        .win       (win_reg),
        .sp_center (bf3_pkg::sat_weight(sp_ctr_reg)),
        .sp_edge   (bf3_pkg::sat_weight(sp_edge_reg)),
        .sp_corner (bf3_pkg::sat_weight(sp_crn_reg)),
        .tbl_wr    (tbl_wr),
        .done      (core_done),
        .res       (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= bf3_pkg::DIM_W'(768);
            height_reg  <= bf3_pkg::DIM_W'(512);
            sp_ctr_reg  <= bf3_pkg::CFG_DATA_W'(65536);
            sp_edge_reg <= bf3_pkg::CFG_DATA_W'(8869);
            sp_crn_reg  <= bf3_pkg::CFG_DATA_W'(1200);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bf3_pkg::REG_IMAGE_WIDTH:  width_reg   <= cfg_data[bf3_pkg::DIM_W-1:0];
                bf3_pkg::REG_IMAGE_HEIGHT: height_reg  <= cfg_data[bf3_pkg::DIM_W-1:0];
                bf3_pkg::REG_SPATIAL_CTR:  sp_ctr_reg  <= cfg_data;
                bf3_pkg::REG_SPATIAL_EDGE: sp_edge_reg <= cfg_data;
                bf3_pkg::REG_SPATIAL_CRN:  sp_crn_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLEAR;
            clr_cnt_reg       <= '0;
            row_count_reg     <= '0;
            col_count_reg     <= '0;
            win_reg           <= '0;
            drain_reg         <= 1'b0;
            p_reg             <= '0;
            sel_reg           <= '0;
            pend2_reg         <= 1'b0;
            cur_row_end_reg   <= 1'b0;
            cur_frame_end_reg <= 1'b0;
            frame_end2_reg    <= 1'b0;
            hold_reg          <= '0;
            out_valid_reg     <= 1'b0;
            out_pix_reg       <= '0;
            out_row_end_reg   <= 1'b0;
            out_frame_end_reg <= 1'b0;
            out_zero_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !(state_reg == S_PUSH && can_load))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == bf3_pkg::COL_W'(bf3_pkg::WIDTH_MAX - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        p_reg     <= pixel_value;
                        drain_reg <= kind == bf3_pkg::KIND_DRAIN;
                        if ((kind == bf3_pkg::KIND_PIXEL && !draining)
                            || (kind == bf3_pkg::KIND_DRAIN && draining))
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    win_reg[0] <= win_reg[1];
                    win_reg[1] <= win_reg[2];
                    win_reg[2] <= sh_top;
                    win_reg[3] <= win_reg[4];
                    win_reg[4] <= win_reg[5];
                    win_reg[5] <= sh_mid;
                    win_reg[6] <= win_reg[7];
                    win_reg[7] <= win_reg[8];
                    win_reg[8] <= sh_bot;
                    if (last)
                    begin
                        col_count_reg <= '0;
                        row_count_reg <= drain_reg ? '0 : row_count_reg + 1'b1;
                    end
                    else
                    begin
                        col_count_reg <= col_count_reg + 1'b1;
                    end
                    // column -1 mirrors to column 1
                    sel_reg.lc <= (col_count_reg == bf3_pkg::COL_W'(1)) ? 2'd2 : 2'd0;
                    sel_reg.cc <= 2'd1;
                    sel_reg.rc <= 2'd2;
                    cur_row_end_reg   <= 1'b0;
                    cur_frame_end_reg <= 1'b0;
                    pend2_reg         <= last;
                    frame_end2_reg    <= drain_reg;
                    state_reg <= emit_any ? S_RUN : S_IDLE;
                end
                S_RUN:
                begin
                    if (core_done)
                    begin
                        hold_reg  <= core_res;
                        state_reg <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    if (can_load)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_pix_reg       <= hold_reg.value;
                        out_zero_reg      <= hold_reg.zero_weight;
                        out_row_end_reg   <= cur_row_end_reg;
                        out_frame_end_reg <= cur_frame_end_reg;
                        if (pend2_reg)
                        begin
                            // column W mirrors to column W-2
                            pend2_reg         <= 1'b0;
                            sel_reg.lc        <= 2'd1;
                            sel_reg.cc        <= 2'd2;
                            sel_reg.rc        <= 2'd1;
                            cur_row_end_reg   <= 1'b1;
                            cur_frame_end_reg <= frame_end2_reg;
                            state_reg         <= S_RUN;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_pixel = out_pix_reg;
    assign row_end        = out_row_end_reg;
    assign frame_end      = out_frame_end_reg;
    assign zero_weight    = out_zero_reg;

endmodule
`default_nettype wire

FILE: rtl/bf3_checker.sv
`default_nettype none
`include "bilateral_filter_3x3_top_defines.svh"
module bf3_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             in_valid,
    input wire logic                             in_ready,
    input wire logic [1:0]                       kind,
    input wire logic                             out_valid,
    input wire logic                             out_ready,
    input wire logic [bf3_pkg::PIX_W-1:0]        filtered_pixel,
    input wire logic                             row_end,
    input wire logic                             frame_end,
    input wire logic                             cfg_ready
);

    // a stalled result holds
    `BF3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(filtered_pixel))
    // frame end only on the last pixel of a row
    `BF3_ASSERT_NOW(a_frame_row, out_valid && frame_end, row_end)
    // table loads and unknown kinds never start filter work
    `BF3_ASSERT_NEXT(a_no_work, in_valid && in_ready && (kind == bf3_pkg::KIND_TABLE || kind == bf3_pkg::KIND_NONE), in_ready)
    // config port never back-pressures
    `BF3_ASSERT_NOW(a_cfg_rdy, 1'b1, cfg_ready)

endmodule

bind bilateral_filter_3x3_top bf3_checker u_bf3_checker (.*);
`default_nettype wire
